### rtl/jalali_dilami_date_converter_top_macros.svh
// Assertion macros for the date converter. Empty bodies when SYNTH is set.
`ifndef JALALI_DILAMI_DATE_CONVERTER_TOP_MACROS_SVH
`define JALALI_DILAMI_DATE_CONVERTER_TOP_MACROS_SVH
`ifndef SYNTH
`define JDC_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define JDC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define JDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define JDC_ASSERT_ALWAYS(lbl, expr, msg)
`define JDC_ASSERT_IMPL(lbl, ante, cons, msg)
`define JDC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/jdc_pkg.sv
`default_nettype none
package jdc_pkg;

	localparam int YEAR_W  = 11;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;

	localparam int MAX_JALALI_YEAR = 1503;
	localparam int ANCHOR_COUNT    = 47;

	// direction codes
	localparam logic KIND_J2D = 1'b0;
	localparam logic KIND_D2J = 1'b1;

	localparam logic [7:0] OFF_LO = 8'd194;
	localparam logic [7:0] OFF_HI = 8'd195;

	localparam logic [YEAR_W-1:0] ANCHORS [ANCHOR_COUNT] = '{
		11'd4,    11'd37,   11'd66,   11'd99,   11'd132,  11'd165,  11'd198,  11'd231,
		11'd264,  11'd297,  11'd326,  11'd359,  11'd392,  11'd425,  11'd458,  11'd491,
		11'd524,  11'd553,  11'd586,  11'd619,  11'd656,  11'd685,  11'd718,  11'd751,
		11'd784,  11'd817,  11'd850,  11'd883,  11'd916,  11'd949,  11'd978,  11'd1011,
		11'd1044, 11'd1077, 11'd1110, 11'd1143, 11'd1176, 11'd1209, 11'd1238, 11'd1275,
		11'd1308, 11'd1343, 11'd1370, 11'd1401, 11'd1436, 11'd1473, 11'd1502
	};

	// First leap year of segment k (k = 1 .. ANCHOR_COUNT). Segment k-1 holds years of
	// residue (k-1) mod 4; the first such year past its anchor is skipped and the
	// sequence resumes one year later.
	function automatic logic [YEAR_W-1:0] seg_start(input int k);
		int a;
		int pad;
		a   = int'(ANCHORS[k-1]);
		pad = ((k - 1) - (a + 1)) & 3;
		return YEAR_W'(a + 2 + pad);
	endfunction

endpackage
`default_nettype wire

### rtl/jdc_if.sv
`default_nettype none
interface jdc_in_if;
	import jdc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 kind;
	logic [YEAR_W-1:0]    year_in;
	logic [MONTH_W-1:0]   month_in;
	logic [DAY_W-1:0]     day_in;

	modport source (output valid, output kind, output year_in, output month_in,
		output day_in, input ready);
	modport sink (input valid, input kind, input year_in, input month_in,
		input day_in, output ready);
endinterface

interface jdc_out_if;
	import jdc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [YEAR_W-1:0]    year_out;
	logic [MONTH_W-1:0]   month_out;
	logic [DAY_W-1:0]     day_out;
	logic                 range_error;

	modport source (output valid, output year_out, output month_out, output day_out,
		output range_error, input ready);
	modport sink (input valid, input year_out, input month_out, input day_out,
		input range_error, output ready);
endinterface
`default_nettype wire

### rtl/jalali_dilami_date_converter_top.sv
`default_nettype none
`include "jalali_dilami_date_converter_top_macros.svh"
// Jalali / Dilami date converter.
// Input channel date_in carries one date per beat: kind (0 Jalali to Dilami,
// 1 Dilami to Jalali), year_in, month_in, day_in. Output channel date_out
// carries one result beat per input beat: year_out, month_out, day_out and
// range_error, in input order.
// The pipe has three registered stages between date_in and date_out: stage 1
// applies the 194/195 year offset and the range check, stage 2 compares the
// Jalali year against all leap segment starts, stage 3 decodes the leap flag
// and maps month and day. Throughput is one date per cycle while date_out.ready
// is high; every stage has its own valid bit.
// Reset clears the valid bits, so date_out is empty and date_in ready afterwards.
// When the receiver holds ready low the output stage keeps its beat, and earlier
// stages keep filling their bubbles; date_in.ready falls only once all three
// stages hold a beat.
module jalali_dilami_date_converter_top #(
	parameter int MAX_JALALI_YEAR = jdc_pkg::MAX_JALALI_YEAR
) (
	input  logic       clk,
	input  logic       arst_n,
	jdc_in_if.sink     date_in,
	jdc_out_if.source  date_out
);
	import jdc_pkg::*;

	localparam logic [YEAR_W-1:0] MAX_Y = YEAR_W'(MAX_JALALI_YEAR);

	logic en1, en2, en3;

	// stage 1
	logic [7:0]          off;
	logic [YEAR_W:0]     diff;
	logic [YEAR_W-1:0]   jy_d, yr_d;
	logic                err_d;
	logic                valid_s1, kind_s1, err_s1;
	logic [YEAR_W-1:0]   jy_s1, yr_s1;
	logic [MONTH_W-1:0]  month_s1;
	logic [DAY_W-1:0]    day_s1;

	// stage 2
	logic                valid_s2, kind_s2, err_s2;
	logic [YEAR_W-1:0]   yr_s2;
	logic [MONTH_W-1:0]  month_s2;
	logic [DAY_W-1:0]    day_s2;
	logic                leap;

	// stage 3
	logic [YEAR_W-1:0]   ry;
	logic [MONTH_W-1:0]  rm;
	logic [DAY_W-1:0]    rd;
	logic [DAY_W-1:0]    split;
	logic [MONTH_W-1:0]  dm;
	logic                valid_s3, err_s3;
	logic [YEAR_W-1:0]   year_s3;
	logic [MONTH_W-1:0]  month_s3;
	logic [DAY_W-1:0]    day_s3;

	assign en3 = !valid_s3 || date_out.ready;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign date_in.ready = en1;

	// year offset and range check
	always_comb begin
		if (date_in.kind == KIND_J2D) begin
			off = (date_in.month_in < 4'd5 ||
				(date_in.month_in == 4'd5 && date_in.day_in < 5'd17)) ? OFF_LO : OFF_HI;
		end else if (date_in.month_in == 4'd0) begin
			off = OFF_LO;
		end else begin
			off = (date_in.month_in < 4'd8 ||
				(date_in.month_in == 4'd8 && date_in.day_in <= 5'd15)) ? OFF_HI : OFF_LO;
		end
		diff = {1'b0, date_in.year_in} - (YEAR_W+1)'(off);
		if (date_in.kind == KIND_J2D) begin
			jy_d  = date_in.year_in;
			yr_d  = date_in.year_in + YEAR_W'(off);
			err_d = date_in.year_in > MAX_Y;
		end else begin
			jy_d  = diff[YEAR_W-1:0];
			yr_d  = diff[YEAR_W-1:0];
			err_d = diff[YEAR_W] || (diff[YEAR_W-1:0] > MAX_Y);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			kind_s1  <= 1'b0;
			err_s1   <= 1'b0;
			jy_s1    <= '0;
			yr_s1    <= '0;
			month_s1 <= '0;
			day_s1   <= '0;
		end else if (en1) begin
			valid_s1 <= date_in.valid;
			kind_s1  <= date_in.kind;
			err_s1   <= err_d;
			jy_s1    <= jy_d;
			yr_s1    <= yr_d;
			month_s1 <= date_in.month_in;
			day_s1   <= date_in.day_in;
		end
	end

	jdc_leap u_leap (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (en2),
		.year   (jy_s1),
		.leap   (leap)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			kind_s2  <= 1'b0;
			err_s2   <= 1'b0;
			yr_s2    <= '0;
			month_s2 <= '0;
			day_s2   <= '0;
		end else if (en2) begin
			valid_s2 <= valid_s1;
			kind_s2  <= kind_s1;
			err_s2   <= err_s1;
			yr_s2    <= yr_s1;
			month_s2 <= month_s1;
			day_s2   <= day_s1;
		end
	end

	// month and day mapping
	always_comb begin
		ry    = yr_s2;
		rm    = '0;
		rd    = '0;
		split = '0;
		dm    = month_s2 - 4'd4;
		if (kind_s2 == KIND_J2D) begin
			rd = leap ? 5'd6 : 5'd0;
			unique case (month_s2)
				4'd1: begin
					priority if (leap && day_s2 == 5'd15) begin
						rm = 4'd0; rd = 5'd0;
					end else if (leap && day_s2 < 5'd15) begin
						rm = 4'd8; rd = day_s2 + 5'd16;
					end else if (!leap && day_s2 < 5'd16) begin
						rm = 4'd8; rd = day_s2 + 5'd15;
					end else if (day_s2 > 5'd15 && day_s2 < 5'd21) begin
						rm = 4'd0; rd = day_s2 - 5'd15;
					end else if (day_s2 > 5'd20) begin
						rm = 4'd9; rd = day_s2 - 5'd20;
					end
				end
				4'd2, 4'd3, 4'd4: begin
					split = 5'd21 - {1'b0, month_s2};
					if (day_s2 > split) begin
						rm = month_s2 + 4'd8; rd = day_s2 - split;
					end else begin
						rm = month_s2 + 4'd7; rd = day_s2 + 5'd9 + {1'b0, month_s2};
					end
				end
				4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12: begin
					split = (month_s2 == 4'd5) ? 5'd16 :
						(month_s2 == 4'd6) ? 5'd15 : 5'd14;
					if (day_s2 > split) begin
						rm = dm; rd = day_s2 - split;
					end else begin
						rm = (month_s2 == 4'd5) ? 4'd12 : dm - 4'd1;
						rd = day_s2 + (5'd30 - split);
					end
				end
				default: ;
			endcase
		end else begin
			unique case (month_s2)
				4'd0: begin
					rm = 4'd1; rd = day_s2 + 5'd15;
				end
				4'd1: begin
					if (day_s2 <= 5'd15) begin
						rm = 4'd5; rd = day_s2 + 5'd16;
					end else begin
						rm = 4'd6; rd = day_s2 - 5'd15;
					end
				end
				4'd2: begin
					if (day_s2 <= 5'd16) begin
						rm = 4'd6; rd = day_s2 + 5'd15;
					end else begin
						rm = 4'd7; rd = day_s2 - 5'd16;
					end
				end
				4'd3, 4'd4, 4'd5, 4'd6, 4'd7: begin
					if (day_s2 <= 5'd16) begin
						rm = month_s2 + 4'd4; rd = day_s2 + 5'd14;
					end else begin
						rm = month_s2 + 4'd5; rd = day_s2 - 5'd16;
					end
				end
				4'd8: begin
					if (day_s2 <= 5'd15 + {4'b0, leap}) begin
						rm = 4'd12; rd = day_s2 + 5'd14;
					end else begin
						rm = 4'd1; rd = day_s2 - 5'd15 - {4'b0, leap};
					end
					// day 16 of a leap year still belongs to the previous year
					if (leap && day_s2 == 5'd16) begin
						ry = yr_s2 - YEAR_W'(1);
					end
				end
				4'd9, 4'd10, 4'd11, 4'd12: begin
					if (day_s2 <= 5'd16) begin
						rm = month_s2 - 4'd8;
						rd = day_s2 + (5'd29 - {1'b0, month_s2});
					end else begin
						rm = month_s2 - 4'd7;
						rd = day_s2 - ({1'b0, month_s2} + 5'd2);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			err_s3   <= 1'b0;
			year_s3  <= '0;
			month_s3 <= '0;
			day_s3   <= '0;
		end else if (en3) begin
			valid_s3 <= valid_s2;
			err_s3   <= err_s2;
			year_s3  <= err_s2 ? '0 : ry;
			month_s3 <= err_s2 ? '0 : rm;
			day_s3   <= err_s2 ? '0 : rd;
		end
	end

	assign date_out.valid       = valid_s3;
	assign date_out.year_out    = year_s3;
	assign date_out.month_out   = month_s3;
	assign date_out.day_out     = day_s3;
	assign date_out.range_error = err_s3;

	`JDC_ASSERT_NEXT(a_j2d_range,
		date_in.valid && date_in.ready && date_in.kind == KIND_J2D && date_in.year_in > MAX_Y,
		valid_s1 && err_s1, "out-of-range Jalali year not flagged")
	`JDC_ASSERT_IMPL(a_ready_full, !date_in.ready, valid_s1 && valid_s2 && valid_s3,
		"input stalled with a bubble in the pipe")
	`JDC_ASSERT_NEXT(a_s2_hold, valid_s2 && !en3, valid_s2 && $stable(yr_s2),
		"stage 2 beat lost during stall")
	`JDC_ASSERT_ALWAYS(a_err_zero,
		!(valid_s3 && err_s3) || (year_s3 == '0 && month_s3 == '0 && day_s3 == '0),
		"error result not cleared")

endmodule
`default_nettype wire

### rtl/jdc_leap.sv
`default_nettype none
`include "jalali_dilami_date_converter_top_macros.svh"
module jdc_leap (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic [jdc_pkg::YEAR_W-1:0] year,
	output logic                      leap
);
	import jdc_pkg::*;

	logic [ANCHOR_COUNT:1]   thermo_d;
	logic                    skip_d;
	logic [ANCHOR_COUNT:1]   thermo_s2;
	logic                    skip_s2;
	logic [1:0]              lsb_s2;
	logic [ANCHOR_COUNT+1:1] thermo_ext;
	logic [1:0]              seg_mod;

	// compare against every segment start in parallel
	always_comb begin
		skip_d = 1'b0;
		for (int k = 1; k <= ANCHOR_COUNT; k++) begin
			thermo_d[k] = (year >= seg_start(k));
			skip_d      = skip_d | (year == (seg_start(k) - YEAR_W'(1)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thermo_s2 <= '0;
			skip_s2   <= 1'b0;
			lsb_s2    <= '0;
		end else if (load) begin
			thermo_s2 <= thermo_d;
			skip_s2   <= skip_d;
			lsb_s2    <= year[1:0];
		end
	end

	// segment index mod 4 from the top edge of the thermometer
	always_comb begin
		thermo_ext = {1'b0, thermo_s2};
		seg_mod    = '0;
		for (int k = 1; k <= ANCHOR_COUNT; k++) begin
			seg_mod = seg_mod | ({2{thermo_ext[k] & ~thermo_ext[k+1]}} & 2'(k));
		end
	end

	assign leap = (lsb_s2 == seg_mod) && !skip_s2;

	`JDC_ASSERT_NEXT(a_year_zero_leap, load && (year == '0), leap, "year 0 not leap")
	`JDC_ASSERT_NEXT(a_year_four_leap, load && (year == YEAR_W'(4)), leap, "year 4 not leap")
	`JDC_ASSERT_NEXT(a_year_eight_plain, load && (year == YEAR_W'(8)), !leap,
		"year 8 taken as leap")

endmodule
`default_nettype wire
